[sv/assert_macros.svh]
// Assertion macros shared by the session gap tracker RTL.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, skipped while reset is high.
`define SGT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("session gap tracker assertion failed");

// Checked at every rising edge, reset included.
`define SGT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("session gap tracker assertion failed");

`endif

[sv/sgt_pkg.sv]
// Shared widths, constants and types of the session gap tracker.
// No dependencies; imported by the interfaces and all modules but sgt_ram.
`timescale 1ns / 1ps

package sgt_pkg;

   localparam int SESSION_BITS = 10;
   localparam int SEQ_BITS     = 32;
   localparam int LEN_BITS     = 16;
   localparam int OUT_CNT_BITS = 48;

   localparam logic [SEQ_BITS-1:0] SEQ_STEP_ONE = 32'h0000_0001;
   localparam logic [SEQ_BITS-1:0] SEQ30_TOP    = 32'h3fff_ffff;

   typedef struct packed {
      logic                gap;
      logic                first;
      logic [SEQ_BITS-1:0] size;
   } step_result_type;

endpackage

[sv/sgt_req_if.sv]
// Request channel of the session gap tracker: one packet word per handshake.
// Depends on sgt_pkg.
`timescale 1ns / 1ps

interface sgt_req_if
   import sgt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [SESSION_BITS-1:0] session;
   logic [SEQ_BITS-1:0]     seq_number;
   logic [LEN_BITS-1:0]     payload_length;

   modport source (output valid, session, seq_number, payload_length, input ready);
   modport sink   (input valid, session, seq_number, payload_length, output ready);
endinterface

[sv/sgt_rsp_if.sv]
// Response channel of the session gap tracker: updated session figures per word.
// Depends on sgt_pkg.
`timescale 1ns / 1ps

interface sgt_rsp_if
   import sgt_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    gap_seen;
   logic [SEQ_BITS-1:0]     gap_size;
   logic                    first_in_session;
   logic [OUT_CNT_BITS-1:0] packets_total;
   logic [OUT_CNT_BITS-1:0] bytes_total;
   logic [OUT_CNT_BITS-1:0] dropped_total;
   logic [OUT_CNT_BITS-1:0] gaps_total;

   modport source (output valid, gap_seen, gap_size, first_in_session, packets_total,
                   bytes_total, dropped_total, gaps_total, input ready);
   modport sink   (input valid, gap_seen, gap_size, first_in_session, packets_total,
                   bytes_total, dropped_total, gaps_total, output ready);
endinterface

[sv/sgt_ram.sv]
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sgt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sgt_step.sv]
// Sequence step check: wrapped difference, 30-bit wrap rule, gap magnitude.
// Depends on sgt_pkg.
`timescale 1ns / 1ps

module sgt_step
   import sgt_pkg::*;
(
   input  logic [SEQ_BITS-1:0] last_seq,
   input  logic [SEQ_BITS-1:0] new_seq,
   output step_result_type     result
);

   logic [SEQ_BITS-1:0] diff;
   logic [SEQ_BITS-1:0] magnitude;
   logic                wrap30;
   logic                in_order;

   always_comb begin
      diff      = new_seq - last_seq;
      wrap30    = (new_seq == '0) && (last_seq == SEQ30_TOP);
      in_order  = (diff == SEQ_STEP_ONE) || wrap30;
      // negation of the most negative step stays 2^31, which is its magnitude
      magnitude = diff[SEQ_BITS-1] ? (SEQ_BITS'(0) - diff) : diff;

      result.first = (last_seq == '0);
      result.gap   = !result.first && !in_order;
      result.size  = result.gap ? magnitude : '0;
   end

endmodule

[sv/session_sequence_gap_tracker.sv]
// Channel  Dir  Handshake              Word contents
// req_port in   valid/ready            session, seq_number, payload_length
// rsp_port out  valid/ready            gap_seen, gap_size, first_in_session, totals
//
// Each word goes through accept, session reduction plus table read, read return
// plus step check, counter update plus write-back; one word at a time is in the table loop.
// After reset a clearing pass writes all SESSIONS entries, req idle.
// A waiting response lets one more word in, which then holds in the update state;
// req is not ready again until the response drains.
// Depends on sgt_pkg, sgt_req_if, sgt_rsp_if, sgt_ram, sgt_step, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module session_sequence_gap_tracker
   import sgt_pkg::*;
#(
   parameter int SESSIONS     = 1024,
   parameter int COUNTER_BITS = 48
) (
   input logic       clock,
   input logic       reset,
   sgt_req_if.sink   req_port,
   sgt_rsp_if.source rsp_port
);

   localparam int IDX_W      = $clog2(SESSIONS);
   localparam int CB         = COUNTER_BITS;
   localparam int ENTRY_W    = SEQ_BITS + 4 * CB;
   localparam int QUOT_SHIFT = 20;
   localparam logic [30:0] RECIP = 31'((1 << QUOT_SHIFT) / SESSIONS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = 65'(a) + 65'(b);
      return (s > 65'({CB{1'b1}})) ? {CB{1'b1}} : s[CB-1:0];
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [SESSION_BITS-1:0] session_ff;
   logic [SESSION_BITS-1:0] quot_ff;
   logic [SEQ_BITS-1:0]     seq_ff;
   logic [LEN_BITS-1:0]     len_ff;
   logic [IDX_W-1:0]        idx_ff;

   step_result_type         step_ff;
   logic [CB-1:0]           gaps_ff, dropped_ff, pkts_ff, bytes_ff;

   logic                    gap_out_ff, first_out_ff;
   logic [SEQ_BITS-1:0]     size_out_ff;
   logic [CB-1:0]           pkts_out_ff, bytes_out_ff, dropped_out_ff, gaps_out_ff;

   logic [30:0]             quot_prod;
   logic [20:0]             rem_full;
   logic [10:0]             rem;
   logic [IDX_W-1:0]        idx;

   logic                    ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data, ram_rd_data;
   step_result_type         step_res;

   logic                    accept, out_free;
   logic [CB-1:0]           pkts_new, bytes_new, gaps_new, dropped_new;

   assign accept   = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE);

   // session modulo SESSIONS: reciprocal quotient at accept, one correction later
   assign quot_prod = 31'(req_port.session) * RECIP;

   always_comb begin
      rem_full = 21'(session_ff) - 21'(quot_ff) * 21'(SESSIONS);
      rem      = rem_full[10:0];
      if (rem >= 11'(SESSIONS)) begin
         rem = rem - 11'(SESSIONS);
      end
      idx = rem[IDX_W-1:0];
   end

   sgt_step u_step (
      .last_seq (ram_rd_data[ENTRY_W-1 -: SEQ_BITS]),
      .new_seq  (seq_ff),
      .result   (step_res)
   );

   always_comb begin
      pkts_new    = sat_add(pkts_ff, 64'd1);
      bytes_new   = sat_add(bytes_ff, 64'(len_ff));
      gaps_new    = step_ff.gap ? sat_add(gaps_ff, 64'd1) : gaps_ff;
      dropped_new = step_ff.gap ? sat_add(dropped_ff, 64'(step_ff.size)) : dropped_ff;
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = {seq_ff, gaps_new, dropped_new, pkts_new, bytes_new};
      ram_rd_en   = (state_ff == ST_LOOK);
      state_in    = state_ff;
      clr_in      = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(SESSIONS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               ram_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   sgt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SESSIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         session_ff <= req_port.session;
         quot_ff    <= quot_prod[QUOT_SHIFT +: SESSION_BITS];
         seq_ff     <= req_port.seq_number;
         len_ff     <= req_port.payload_length;
      end
      if (state_ff == ST_LOOK) begin
         idx_ff <= idx;
      end
      if (state_ff == ST_READ) begin
         step_ff    <= step_res;
         gaps_ff    <= ram_rd_data[3*CB +: CB];
         dropped_ff <= ram_rd_data[2*CB +: CB];
         pkts_ff    <= ram_rd_data[CB +: CB];
         bytes_ff   <= ram_rd_data[0 +: CB];
      end
      if (state_ff == ST_UPD && out_free) begin
         gap_out_ff     <= step_ff.gap;
         first_out_ff   <= step_ff.first;
         size_out_ff    <= step_ff.size;
         pkts_out_ff    <= pkts_new;
         bytes_out_ff   <= bytes_new;
         dropped_out_ff <= dropped_new;
         gaps_out_ff    <= gaps_new;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.gap_seen         = gap_out_ff;
   assign rsp_port.gap_size         = size_out_ff;
   assign rsp_port.first_in_session = first_out_ff;
   assign rsp_port.packets_total    = OUT_CNT_BITS'(pkts_out_ff);
   assign rsp_port.bytes_total      = OUT_CNT_BITS'(bytes_out_ff);
   assign rsp_port.dropped_total    = OUT_CNT_BITS'(dropped_out_ff);
   assign rsp_port.gaps_total       = OUT_CNT_BITS'(gaps_out_ff);

   `SGT_ASSERT(a_no_accept_in_clear, (state_ff == ST_CLEAR) |-> !req_port.ready)
   `SGT_ASSERT(a_write_in_clear_or_upd,
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_UPD))
   `SGT_ASSERT(a_rsp_from_upd, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPD)
   `SGT_ASSERT(a_gap_not_first,
      rsp_valid_ff |-> !(gap_out_ff && first_out_ff))
   `SGT_ASSERT(a_size_only_on_gap,
      (rsp_valid_ff && !gap_out_ff) |-> (size_out_ff == '0))

endmodule

[test/session_sequence_gap_tracker_tb.sv]
// Self-checking testbench for session_sequence_gap_tracker: directed and random packet words
// with random idling on both channels, checked against a per-session gap tracking predictor.
// Depends on sgt_pkg, sgt_req_if, sgt_rsp_if and the tracker RTL.
`timescale 1ns / 1ps

module session_sequence_gap_tracker_tb
   import sgt_pkg::*;
;

   localparam int SESSIONS     = 1024;
   localparam int COUNTER_BITS = 48;
   localparam logic [63:0] CNT_MAX = (64'd1 << COUNTER_BITS) - 1;
   localparam int RANDOM_WORDS = 1000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [SESSION_BITS-1:0] session;
      logic [SEQ_BITS-1:0]     seq;
      logic [LEN_BITS-1:0]     len;
   } packet_word_type;

   typedef struct packed {
      logic                    gap;
      logic [SEQ_BITS-1:0]     size;
      logic                    first;
      logic [OUT_CNT_BITS-1:0] packets;
      logic [OUT_CNT_BITS-1:0] bytes;
      logic [OUT_CNT_BITS-1:0] dropped;
      logic [OUT_CNT_BITS-1:0] gaps;
   } session_figures_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sgt_req_if req_bus();
   sgt_rsp_if rsp_bus();

   session_sequence_gap_tracker #(
      .SESSIONS    (SESSIONS),
      .COUNTER_BITS(COUNTER_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [SEQ_BITS-1:0] seen_seq [SESSIONS];
   logic [63:0]         pkt_cnt  [SESSIONS];
   logic [63:0]         byte_cnt [SESSIONS];
   logic [63:0]         drop_cnt [SESSIONS];
   logic [63:0]         gap_cnt  [SESSIONS];

   // stimulus generator state, independent of the predictor
   logic [SEQ_BITS-1:0] gen_last [SESSIONS];

   packet_word_type     pending_words[$];
   session_figures_type figures_due[$];

   int accepted_count = 0;
   int received_count = 0;
   int total_words    = 0;
   int error_count    = 0;
   int mismatch_count = 0;
   int idle_left      = 0;
   int stall_left     = 0;
   logic hold_rsp     = 1'b0;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      if (a > CNT_MAX)
         a = CNT_MAX;
      if (b > CNT_MAX - a)
         return CNT_MAX;
      return a + b;
   endfunction

   function session_figures_type track_packet(packet_word_type w);
      int unsigned         idx;
      logic [SEQ_BITS-1:0] prior;
      logic [SEQ_BITS-1:0] step;
      logic [SEQ_BITS-1:0] neg;
      session_figures_type f;
      idx   = w.session % SESSIONS;
      prior = seen_seq[idx];
      f     = '0;
      pkt_cnt[idx]  = sat_add(pkt_cnt[idx], 64'd1);
      byte_cnt[idx] = sat_add(byte_cnt[idx], {48'd0, w.len});
      if (prior == '0) begin
         f.first = 1'b1;
      end else begin
         step = w.seq - prior;
         if (w.seq == '0 && prior == SEQ30_TOP)
            step = SEQ_STEP_ONE;
         if (step != SEQ_STEP_ONE) begin
            neg    = -step;
            f.gap  = 1'b1;
            f.size = step[SEQ_BITS-1] ? neg : step;
            gap_cnt[idx]  = sat_add(gap_cnt[idx], 64'd1);
            drop_cnt[idx] = sat_add(drop_cnt[idx], {32'd0, f.size});
         end
      end
      seen_seq[idx] = w.seq;
      f.packets = pkt_cnt[idx][OUT_CNT_BITS-1:0];
      f.bytes   = byte_cnt[idx][OUT_CNT_BITS-1:0];
      f.dropped = drop_cnt[idx][OUT_CNT_BITS-1:0];
      f.gaps    = gap_cnt[idx][OUT_CNT_BITS-1:0];
      return f;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_packet(int sess, logic [SEQ_BITS-1:0] seq, int len);
      packet_word_type w;
      w.session = sess[SESSION_BITS-1:0];
      w.seq     = seq;
      w.len     = len[LEN_BITS-1:0];
      pending_words.push_back(w);
      total_words++;
   endtask

   task automatic add_random_packet();
      int                  sess;
      int                  k;
      int                  hot [8];
      logic [SEQ_BITS-1:0] seq;
      logic [SEQ_BITS-1:0] prev;
      hot = '{0, 1, 2, 3, 511, 512, 1022, 1023};
      if ($urandom_range(0, 99) < 75)
         sess = hot[$urandom_range(0, 7)];
      else
         sess = $urandom_range(0, SESSIONS - 1);
      prev = gen_last[sess];
      k    = $urandom_range(0, 99);
      if (prev == SEQ30_TOP && k < 40)
         seq = '0;
      else if (k < 70)
         seq = prev + 1;
      else if (k < 80)
         seq = prev + $urandom_range(2, 20);
      else if (k < 85)
         seq = prev - $urandom_range(0, 5);
      else if (k < 90)
         seq = $urandom;
      else if (k < 93)
         seq = '0;
      else if (k < 96)
         seq = SEQ30_TOP;
      else if (k < 98)
         seq = 32'hffff_ffff;
      else
         seq = prev ^ 32'h8000_0000;
      gen_last[sess] = seq;
      if ($urandom_range(0, 99) < 10)
         add_packet(sess, seq, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
      else
         add_packet(sess, seq, $urandom_range(0, 65535));
   endtask

   // request driver
   always @(posedge clock) begin
      packet_word_type w;
      logic            next_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            w.session = req_bus.session;
            w.seq     = req_bus.seq_number;
            w.len     = req_bus.payload_length;
            figures_due.push_back(track_packet(w));
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            next_valid = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_words.size() != 0) begin
               w = pending_words.pop_front();
               req_bus.session        <= w.session;
               req_bus.seq_number     <= w.seq;
               req_bus.payload_length <= w.len;
               next_valid = 1'b1;
               idle_left  = (accepted_count % 256 < 64) ? 0 : pick_idle();
            end
            req_bus.valid <= next_valid;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      session_figures_type got;
      session_figures_type want;
      logic                next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.gap     = rsp_bus.gap_seen;
            got.size    = rsp_bus.gap_size;
            got.first   = rsp_bus.first_in_session;
            got.packets = rsp_bus.packets_total;
            got.bytes   = rsp_bus.bytes_total;
            got.dropped = rsp_bus.dropped_total;
            got.gaps    = rsp_bus.gaps_total;
            received_count++;
            if (figures_due.size() == 0) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result word %0d with no word outstanding",
                           $realtime, received_count);
            end else begin
               want = figures_due.pop_front();
               if (got !== want) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result word %0d mismatch", $realtime, received_count);
                     $display("  gap_seen   exp %0d act %0d", want.gap, got.gap);
                     $display("  gap_size   exp %h act %h", want.size, got.size);
                     $display("  first      exp %0d act %0d", want.first, got.first);
                     $display("  packets    exp %h act %h", want.packets, got.packets);
                     $display("  bytes      exp %h act %h", want.bytes, got.bytes);
                     $display("  dropped    exp %h act %h", want.dropped, got.dropped);
                     $display("  gaps       exp %h act %h", want.gaps, got.gaps);
                  end
               end
            end
         end
         next_ready = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (received_count % 256 >= 96 && $urandom_range(0, 99) < 25) begin
            stall_left = pick_idle();
         end
         rsp_bus.ready <= next_ready && !hold_rsp;
      end
   end

   // long receiver hold-off so the block backs up into the request channel
   initial begin
      wait (accepted_count >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.session        = '0;
      req_bus.seq_number     = '0;
      req_bus.payload_length = '0;
      rsp_bus.ready          = 1'b0;
      for (int i = 0; i < SESSIONS; i++) begin
         seen_seq[i] = '0;
         pkt_cnt[i]  = '0;
         byte_cnt[i] = '0;
         drop_cnt[i] = '0;
         gap_cnt[i]  = '0;
         gen_last[i] = '0;
      end

      // zero stored as last number, in-order step, repeat, step back
      add_packet(0, 32'd0, 0);
      add_packet(0, 32'd5, 16'hffff);
      add_packet(0, 32'd6, 1);
      add_packet(0, 32'd6, 2);
      add_packet(0, 32'd3, 3);
      // full 32-bit wrap, then a stored zero again
      add_packet(1023, 32'hffff_ffff, 16'hffff);
      add_packet(1023, 32'd0, 0);
      add_packet(1023, 32'd1, 5);
      // 30-bit wrap
      add_packet(1, SEQ30_TOP, 100);
      add_packet(1, 32'd0, 100);
      // most negative step, largest positive step
      add_packet(2, 32'd5, 0);
      add_packet(2, 32'h8000_0005, 0);
      add_packet(3, 32'd1, 7);
      add_packet(3, 32'h8000_0000, 7);
      add_packet(3, 32'd0, 7);
      add_packet(4, 32'd10, 1);
      add_packet(4, 32'd9, 1);
      add_packet(4, 32'hffff_fff0, 1);
      // alternating bit patterns on every field
      add_packet(10'h2aa, 32'haaaa_aaaa, 16'haaaa);
      add_packet(10'h155, 32'h5555_5555, 16'h5555);
      add_packet(10'h2aa, 32'h5555_5555, 16'h5555);
      add_packet(10'h155, 32'h5555_5556, 16'haaaa);
      for (int i = 0; i < 4; i++)
         gen_last[i] = (i == 0) ? 32'd3 : (i == 1) ? 32'd0 : (i == 2) ? 32'h8000_0005 : 32'd0;
      gen_last[1023] = 32'd1;

      for (int i = 0; i < RANDOM_WORDS; i++)
         add_random_packet();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_words || figures_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/sgt_pkg.sv
sv/sgt_req_if.sv
sv/sgt_rsp_if.sv
sv/sgt_ram.sv
sv/sgt_step.sv
sv/session_sequence_gap_tracker.sv
test/session_sequence_gap_tracker_tb.sv
